// ===== sv/rt_pkg.sv =====
// ----------------------------------------------------------------------------
// rt_pkg: shared types for the record table
// Command codes, status codes, the token that walks the cell chain and the
// result word handed out on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

package rt_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ID_W      = 16;
    localparam int AGE_W     = 16;
    localparam int GRP_W     = 3;
    localparam int INS_W     = 3;
    localparam int SLOT_W    = 6;
    localparam int STAT_W    = 2;

    typedef enum logic [2:0] {
        CMD_CLEAR    = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_FIND_ID  = 3'd2,
        CMD_FIND_AGE = 3'd3,
        CMD_DELETE   = 3'd4,
        CMD_DROP_GRP = 3'd5
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // Command token: request fields plus the result gathered along the chain
    typedef struct packed {
        t_cmd              cmd;
        logic [ID_W-1:0]   key;
        logic [AGE_W-1:0]  age;
        logic [GRP_W-1:0]  grp;
        logic [INS_W-1:0]  ins;
        logic [ID_W-1:0]   new_id;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   r_id;
        logic [AGE_W-1:0]  r_age;
        logic [GRP_W-1:0]  r_grp;
        logic [INS_W-1:0]  r_ins;
    } t_token;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [AGE_W-1:0]  age;
        logic [GRP_W-1:0]  grp;
        logic [INS_W-1:0]  ins;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/record_table_with_slot_allocation.sv =====
// ----------------------------------------------------------------------------
// record_table_with_slot_allocation: record table with free-slot allocation
// Chain of slot cells swept by one command token per command.
// ----------------------------------------------------------------------------
// Each command word enters as a token at cell 0 and moves one cell per
// cycle down a chain of SLOTS cells, each cell holding one record (valid,
// id, age, group, instrument). Lower slots see the token first, so the
// first free or matching cell claims it and the lowest slot wins. Clear and
// drop-group act on every cell as the token passes; drop-group compares the
// stored group whether or not the slot is valid. A command passes through
// every cell register and then the output register before its result word
// is valid. Only one command is in the chain at a time: the next command is
// accepted after the token leaves the last cell, once the busy flag has
// cleared and the holding register is empty. A result that is not taken
// waits in the output register, and a second one in a holding register; the
// input side stays open while the output stalls until the holding register
// fills. Insert bumps the 16-bit id counter (wrapping) and stores the new
// value; a full table leaves the counter alone. The slot field shows the
// low 6 bits of the slot index. Undefined commands change nothing and report
// not found. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module record_table_with_slot_allocation #(
    parameter int SLOTS = rt_pkg::SLOTS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  [2:0]                 i_cmd,
    input  wire  [rt_pkg::ID_W-1:0]    i_key,
    input  wire  [rt_pkg::AGE_W-1:0]   i_age,
    input  wire  [rt_pkg::GRP_W-1:0]   i_group,
    input  wire  [rt_pkg::INS_W-1:0]   i_instrument,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic [rt_pkg::STAT_W-1:0]  o_status,
    output logic [rt_pkg::SLOT_W-1:0]  o_slot,
    output logic [rt_pkg::ID_W-1:0]    o_rec_id,
    output logic [rt_pkg::AGE_W-1:0]   o_rec_age,
    output logic [rt_pkg::GRP_W-1:0]   o_rec_group,
    output logic [rt_pkg::INS_W-1:0]   o_rec_instrument
);
    import rt_pkg::*;

    // token links: link k feeds cell k, link SLOTS leaves the chain
    logic   tok_vld [0:SLOTS];
    t_token tok     [0:SLOTS];

    logic            r_busy;
    logic [ID_W-1:0] r_next_id;
    logic            r_out_vld;
    t_result         r_out;
    logic            r_pend_vld;
    t_result         r_pend;

    logic    in_acc;
    logic    out_stall;
    logic    exit_vld;
    t_token  exit_tok;
    t_result exit_res;
    t_token  launch_tok;

    assign o_in_ready = !r_busy && !r_pend_vld;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_stall  = r_out_vld && !i_out_ready;

    // launch: build the token from the input word, result fields start empty
    always_comb begin
        launch_tok        = '0;
        launch_tok.cmd    = t_cmd'(i_cmd);
        launch_tok.key    = i_key;
        launch_tok.age    = i_age;
        launch_tok.grp    = i_group;
        launch_tok.ins    = i_instrument;
        launch_tok.new_id = r_next_id + ID_W'(1);
    end

    assign tok_vld[0] = in_acc;
    assign tok[0]     = launch_tok;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        rt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok_vld (tok_vld[g]),
            .i_tok     (tok[g]),
            .o_tok_vld (tok_vld[g+1]),
            .o_tok     (tok[g+1])
        );
    end

    assign exit_vld = tok_vld[SLOTS];
    assign exit_tok = tok[SLOTS];

    // form the result word from the token leaving the last cell
    always_comb begin
        exit_res        = '0;
        exit_res.status = ST_NOT_FOUND;
        unique case (exit_tok.cmd)
            CMD_CLEAR: begin
                exit_res.status = ST_OK;
            end
            CMD_INSERT: begin
                exit_res.status = ST_FULL;
            end
            CMD_DROP_GRP: begin
                exit_res.status = ST_OK;
                exit_res.grp    = exit_tok.grp;
            end
            default: begin
            end
        endcase
        if (exit_tok.hit) begin
            exit_res.status = ST_OK;
            exit_res.slot   = exit_tok.slot;
            exit_res.id     = exit_tok.r_id;
            exit_res.age    = exit_tok.r_age;
            exit_res.grp    = exit_tok.r_grp;
            exit_res.ins    = exit_tok.r_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_next_id  <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            // hold busy from acceptance until the token leaves the chain
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (exit_vld) begin
                r_busy <= 1'b0;
            end
            // commit the id counter only on a successful insert
            if (exit_vld && exit_tok.cmd == CMD_INSERT && exit_tok.hit) begin
                r_next_id <= exit_tok.new_id;
            end
            // output register, refilled from the holding register first
            if (!out_stall) begin
                r_out_vld <= r_pend_vld || exit_vld;
            end
            if (!out_stall && r_pend_vld) begin
                r_pend_vld <= 1'b0;
            end else if (out_stall && exit_vld) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_stall) begin
            r_out <= r_pend_vld ? r_pend : exit_res;
        end
        if (out_stall && exit_vld) begin
            r_pend <= exit_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_slot           = r_out.slot;
    assign o_rec_id         = r_out.id;
    assign o_rec_age        = r_out.age;
    assign o_rec_group      = r_out.grp;
    assign o_rec_instrument = r_out.ins;

endmodule

`default_nettype wire

// ===== sv/rt_cell.sv =====
// ----------------------------------------------------------------------------
// rt_cell: one slot of the record table
// Holds one record and acts on the command token as it passes, then hands
// the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rt_cell #(
    parameter int IDX = 0
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_tok_vld,
    input  rt_pkg::t_token i_tok,
    output logic           o_tok_vld,
    output rt_pkg::t_token o_tok
);
    import rt_pkg::*;

    logic              r_vld;
    logic [ID_W-1:0]   r_id;
    logic [AGE_W-1:0]  r_age;
    logic [GRP_W-1:0]  r_grp;
    logic [INS_W-1:0]  r_ins;
    logic              r_tok_vld;
    t_token            r_tok;

    logic              n_vld;
    logic              wr_rec;
    t_token            n_tok;
    logic              take;

    always_comb begin
        n_vld  = r_vld;
        wr_rec = 1'b0;
        take   = 1'b0;
        n_tok  = i_tok;
        if (i_tok_vld) begin
            unique case (i_tok.cmd)
                CMD_CLEAR: begin
                    n_vld = 1'b0;
                end
                CMD_INSERT: begin
                    if (!i_tok.hit && !r_vld) begin
                        n_vld  = 1'b1;
                        wr_rec = 1'b1;
                        n_tok.hit   = 1'b1;
                        n_tok.slot  = SLOT_W'(IDX);
                        n_tok.r_id  = i_tok.new_id;
                        n_tok.r_age = i_tok.age;
                        n_tok.r_grp = i_tok.grp;
                        n_tok.r_ins = i_tok.ins;
                    end
                end
                CMD_FIND_ID, CMD_DELETE: begin
                    if (!i_tok.hit && r_vld && r_id == i_tok.key) begin
                        take = 1'b1;
                        if (i_tok.cmd == CMD_DELETE) begin
                            n_vld = 1'b0;
                        end
                    end
                end
                CMD_FIND_AGE: begin
                    if (!i_tok.hit && r_vld && r_age == i_tok.age) begin
                        take = 1'b1;
                    end
                end
                CMD_DROP_GRP: begin
                    if (r_grp == i_tok.grp) begin
                        n_vld = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (take) begin
                n_tok.hit   = 1'b1;
                n_tok.slot  = SLOT_W'(IDX);
                n_tok.r_id  = r_id;
                n_tok.r_age = r_age;
                n_tok.r_grp = r_grp;
                n_tok.r_ins = r_ins;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_tok_vld <= i_tok_vld;
        end
    end

    // record fields and token payload carry no reset
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (wr_rec) begin
            r_id  <= i_tok.new_id;
            r_age <= i_tok.age;
            r_grp <= i_tok.grp;
            r_ins <= i_tok.ins;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

`default_nettype wire

// ===== sv/rt_checker.sv =====
// ----------------------------------------------------------------------------
// rt_checker: port-level checks for the record table
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module rt_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_ready,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [rt_pkg::STAT_W-1:0]   o_status,
    input wire [rt_pkg::SLOT_W-1:0]   o_slot,
    input wire [rt_pkg::ID_W-1:0]     o_rec_id,
    input wire [rt_pkg::AGE_W-1:0]    o_rec_age,
    input wire [rt_pkg::GRP_W-1:0]    o_rec_group,
    input wire [rt_pkg::INS_W-1:0]    o_rec_instrument
);
    import rt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_status) && $stable(o_slot)
            && $stable(o_rec_id) && $stable(o_rec_age))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_OK || o_status == ST_NOT_FOUND
            || o_status == ST_FULL)
        else $error("undefined status code");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_NOT_FOUND)
            |-> o_slot == '0 && o_rec_id == '0 && o_rec_age == '0
            && o_rec_group == '0 && o_rec_instrument == '0)
        else $error("miss result carries record data");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command accepted while one is in the chain");

endmodule

bind record_table_with_slot_allocation rt_checker u_rt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_status         (o_status),
    .o_slot           (o_slot),
    .o_rec_id         (o_rec_id),
    .o_rec_age        (o_rec_age),
    .o_rec_group      (o_rec_group),
    .o_rec_instrument (o_rec_instrument)
);

`default_nettype wire
